/* src/sct_pkg.sv */
// Shared types, constants and elaboration-time table functions for the sine/cosine block.
package sct_pkg;

  // Default configuration of the block.
  localparam int TABLE_SIZE_DEF    = 512;
  localparam int OUT_FRAC_BITS_DEF = 14;

  // Fixed-point constants.
  localparam logic [31:0]        INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [63:0]        PI_HALF_Q30    = 64'd1686629713;
  localparam logic [63:0]        TWO_PI_Q30     = 64'd6746518852;
  localparam logic signed [63:0] ONE_Q30        = 64'sd1073741824;

  // Datapath widths.
  localparam int ROM_W  = 32;  // table entry, signed Q1.30
  localparam int ACC_W  = 33;  // Hermite accumulator, signed Q2.30 with headroom
  localparam int FRAC_W = 30;  // interpolation fraction, unsigned Q0.30
  localparam int DN_W   = 28;  // table step 2*pi/N in Q0.30
  localparam int OUT_W  = 16;  // result field width

  // Register stages inside one interpolation lane.
  localparam int LANE_LAT = 9;

  typedef logic signed [ROM_W-1:0] rom_word_t;
  typedef logic [FRAC_W-1:0]       frac_t;

  // Two neighboring table entries: lo at index n, hi at index n+1.
  typedef struct packed {
    rom_word_t hi;
    rom_word_t lo;
  } rom_pair_t;

  // First-quadrant sine in Q1.30 from a truncated Taylor series. Runs only at
  // elaboration to fill the table.
  function automatic logic [63:0] quarter_sine(input logic [63:0] j, input int qbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        q_half;
    logic signed [63:0] sum;
    q_half = (64'd1 << qbits) >> 1;
    x      = (PI_HALF_Q30 * j + q_half) >> qbits;
    x2     = (x * x) >> 30;
    sum    = $signed(x);
    term   = ((x    * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term   = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term   = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term   = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term   = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term   = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term   = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term   = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    term   = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
    term   = ((term * x2) >> 30) / 64'd420; sum = sum + $signed(term);
    term   = ((term * x2) >> 30) / 64'd506; sum = sum - $signed(term);
    term   = ((term * x2) >> 30) / 64'd600; sum = sum + $signed(term);
    if (sum < 64'sd0) begin
      sum = 64'sd0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return $unsigned(sum);
  endfunction

  // Full-turn table entry k, built from the first quadrant by symmetry.
  function automatic rom_word_t rom_entry(input logic [31:0] k, input int qbits);
    logic [31:0]        q;
    logic [31:0]        j;
    logic [1:0]         quad;
    logic signed [63:0] v;
    q    = 32'd1 << qbits;
    quad = 2'((k >> qbits) & 32'd3);
    j    = k & (q - 32'd1);
    unique case (quad)
      2'd0: v = $signed(quarter_sine(64'(j), qbits));
      2'd1: v = $signed(quarter_sine(64'(q - j), qbits));
      2'd2: v = -$signed(quarter_sine(64'(j), qbits));
      2'd3: v = -$signed(quarter_sine(64'(q - j), qbits));
    endcase
    return ROM_W'(v);
  endfunction

  // Right shift by s with rounding half away from zero; identity for s = 0.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
    logic signed [63:0] half;
    logic signed [63:0] neg_fix;
    if (s == 0) begin
      return v;
    end
    half    = 64'sd1 <<< (s - 1);
    neg_fix = v[63] ? 64'sd1 : 64'sd0;
    return (v + half - neg_fix) >>> s;
  endfunction

endpackage

/* src/sct_rom.sv */
// Dual-bank sine table with registered reads of both neighbor pairs.
module sct_rom #(
  parameter int TABLE_SIZE = sct_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [$clog2(TABLE_SIZE)-1:0] sin_idx_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] cos_idx_i,
  output sct_pkg::rom_pair_t            sin_pair_o,
  output sct_pkg::rom_pair_t            cos_pair_o
);

  localparam int IB    = $clog2(TABLE_SIZE);
  localparam int HALF  = TABLE_SIZE / 2;
  localparam int QBITS = IB - 2;

  // Even entries 0, 2, .., N and odd entries 1, 3, .., N-1. A pair n, n+1
  // always takes one word from each bank.
  sct_pkg::rom_word_t even_rom [0:HALF];
  sct_pkg::rom_word_t odd_rom  [0:HALF-1];

  for (genvar g = 0; g <= HALF; g++) begin : g_even
    localparam sct_pkg::rom_word_t VAL = sct_pkg::rom_entry(32'(2 * g), QBITS);
    assign even_rom[g] = VAL;
  end

  for (genvar g = 0; g < HALF; g++) begin : g_odd
    localparam sct_pkg::rom_word_t VAL = sct_pkg::rom_entry(32'(2 * g + 1), QBITS);
    assign odd_rom[g] = VAL;
  end

  // Bank addresses. For an odd base index the even word is the upper neighbor.
  logic [IB-1:0] s_even_a;
  logic [IB-1:0] c_even_a;
  logic [IB-2:0] s_odd_a;
  logic [IB-2:0] c_odd_a;

  assign s_even_a = {1'b0, sin_idx_i[IB-1:1]} + IB'(sin_idx_i[0]);
  assign c_even_a = {1'b0, cos_idx_i[IB-1:1]} + IB'(cos_idx_i[0]);
  assign s_odd_a  = sin_idx_i[IB-1:1];
  assign c_odd_a  = cos_idx_i[IB-1:1];

  // Registered reads. The cosine index differs by a quarter turn, so it has
  // the same parity as the sine index.
  sct_pkg::rom_word_t s_even_r;
  sct_pkg::rom_word_t s_odd_r;
  sct_pkg::rom_word_t c_even_r;
  sct_pkg::rom_word_t c_odd_r;
  logic               swap_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s_even_r <= even_rom[s_even_a];
      s_odd_r  <= odd_rom[s_odd_a];
      c_even_r <= even_rom[c_even_a];
      c_odd_r  <= odd_rom[c_odd_a];
      swap_r   <= sin_idx_i[0];
    end
  end

  // Put the words back in index order.
  assign sin_pair_o.lo = swap_r ? s_odd_r  : s_even_r;
  assign sin_pair_o.hi = swap_r ? s_even_r : s_odd_r;
  assign cos_pair_o.lo = swap_r ? c_odd_r  : c_even_r;
  assign cos_pair_o.hi = swap_r ? c_even_r : c_odd_r;

endmodule

/* src/sct_lane.sv */
// One cubic Hermite interpolation lane with output rounding and saturation.
module sct_lane #(
  parameter int TABLE_SIZE    = sct_pkg::TABLE_SIZE_DEF,
  parameter int OUT_FRAC_BITS = sct_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  sct_pkg::rom_pair_t                own_i,
  input  sct_pkg::rom_pair_t                slope_i,
  input  sct_pkg::frac_t                    t_i,
  output logic signed [sct_pkg::OUT_W-1:0]  value_o
);

  localparam int AW     = sct_pkg::ACC_W;
  localparam int FW     = sct_pkg::FRAC_W;
  localparam int DW     = sct_pkg::DN_W;
  localparam int PROD_W = sct_pkg::ROM_W + DW + 1;
  localparam int MUL_W  = AW + FW + 1;
  localparam int SH     = 30 - OUT_FRAC_BITS;

  // Table step 2*pi/N in Q0.30.
  localparam logic [DW-1:0] DN =
    DW'((sct_pkg::TWO_PI_Q30 + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE));

  // Saturation limits: plus or minus one, kept inside the 16-bit field.
  localparam logic signed [63:0] LIM = 64'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [63:0] HI  = (LIM > 64'sd32767) ? 64'sd32767 : LIM;
  localparam logic signed [63:0] LO  = (-LIM < -64'sd32768) ? -64'sd32768 : -LIM;

  // Stage 1: slope products.
  logic signed [PROD_W-1:0] mp0_r;
  logic signed [PROD_W-1:0] mp1_r;
  sct_pkg::rom_word_t       p0_1_r;
  sct_pkg::rom_word_t       p1_1_r;
  sct_pkg::frac_t           t_1_r;

  // Stage 2: polynomial coefficients.
  logic signed [AW-1:0] m0_nxt;
  logic signed [AW-1:0] m1_nxt;
  logic signed [AW-1:0] d_nxt;
  logic signed [AW-1:0] a_nxt;
  logic signed [AW-1:0] b_nxt;
  logic signed [AW-1:0] a_2_r;
  logic signed [AW-1:0] b_2_r;
  logic signed [AW-1:0] m0_2_r;
  logic signed [AW-1:0] p0_2_r;
  sct_pkg::frac_t       t_2_r;

  // Stages 3 to 8: three multiply and accumulate steps in Horner form.
  logic signed [MUL_W-1:0] pa_3_r;
  logic signed [AW-1:0]    b_3_r;
  logic signed [AW-1:0]    m0_3_r;
  logic signed [AW-1:0]    p0_3_r;
  sct_pkg::frac_t          t_3_r;
  logic signed [AW-1:0]    acc1_4_r;
  logic signed [AW-1:0]    m0_4_r;
  logic signed [AW-1:0]    p0_4_r;
  sct_pkg::frac_t          t_4_r;
  logic signed [MUL_W-1:0] pb_5_r;
  logic signed [AW-1:0]    m0_5_r;
  logic signed [AW-1:0]    p0_5_r;
  sct_pkg::frac_t          t_5_r;
  logic signed [AW-1:0]    acc2_6_r;
  logic signed [AW-1:0]    p0_6_r;
  sct_pkg::frac_t          t_6_r;
  logic signed [MUL_W-1:0] pc_7_r;
  logic signed [AW-1:0]    p0_7_r;
  logic signed [AW-1:0]    res_8_r;

  // Stage 9: output rounding and saturation.
  logic signed [63:0]               rnd_out;
  logic signed [63:0]               sat_out;
  logic signed [sct_pkg::OUT_W-1:0] value_nxt;

  // Slopes and Hermite coefficients from the products of stage 1.
  always_comb begin
    m0_nxt = AW'(sct_pkg::rnd_shift(64'(mp0_r), 30));
    m1_nxt = AW'(sct_pkg::rnd_shift(64'(mp1_r), 30));
    d_nxt  = AW'(p1_1_r) - AW'(p0_1_r);
    a_nxt  = m0_nxt + m1_nxt - (d_nxt <<< 1);
    b_nxt  = (d_nxt <<< 1) + d_nxt - (m0_nxt <<< 1) - m1_nxt;
  end

  // Final rounding to the output format and clamp to plus or minus one.
  always_comb begin
    rnd_out = sct_pkg::rnd_shift(64'(res_8_r), SH);
    priority if (rnd_out > HI) begin
      sat_out = HI;
    end else if (rnd_out < LO) begin
      sat_out = LO;
    end else begin
      sat_out = rnd_out;
    end
    value_nxt = sct_pkg::OUT_W'(sat_out);
  end

  // The whole lane advances together under the shared enable.
  always_ff @(posedge clk) begin
    if (en) begin
      mp0_r    <= slope_i.lo * $signed({1'b0, DN});
      mp1_r    <= slope_i.hi * $signed({1'b0, DN});
      p0_1_r   <= own_i.lo;
      p1_1_r   <= own_i.hi;
      t_1_r    <= t_i;

      a_2_r    <= a_nxt;
      b_2_r    <= b_nxt;
      m0_2_r   <= m0_nxt;
      p0_2_r   <= AW'(p0_1_r);
      t_2_r    <= t_1_r;

      pa_3_r   <= a_2_r * $signed({1'b0, t_2_r});
      b_3_r    <= b_2_r;
      m0_3_r   <= m0_2_r;
      p0_3_r   <= p0_2_r;
      t_3_r    <= t_2_r;

      acc1_4_r <= AW'(sct_pkg::rnd_shift(pa_3_r, 30)) + b_3_r;
      m0_4_r   <= m0_3_r;
      p0_4_r   <= p0_3_r;
      t_4_r    <= t_3_r;

      pb_5_r   <= acc1_4_r * $signed({1'b0, t_4_r});
      m0_5_r   <= m0_4_r;
      p0_5_r   <= p0_4_r;
      t_5_r    <= t_4_r;

      acc2_6_r <= AW'(sct_pkg::rnd_shift(pb_5_r, 30)) + m0_5_r;
      p0_6_r   <= p0_5_r;
      t_6_r    <= t_5_r;

      pc_7_r   <= acc2_6_r * $signed({1'b0, t_6_r});
      p0_7_r   <= p0_6_r;

      res_8_r  <= AW'(sct_pkg::rnd_shift(pc_7_r, 30)) + p0_7_r;

      value_o  <= value_nxt;
    end
  end

endmodule

/* src/sin_cos_table_hermite.sv */
// Top level of the table-based sine and cosine unit with Hermite interpolation.
//
// Usage. One angle in radians (signed Q15.16) enters on the in_ channel and
// one result, sine and cosine in signed Q1.14 saturated to plus or minus one,
// leaves on the out_ channel. Both channels transfer when valid is high and
// stall is low at a rising clock edge.
//
// Pipeline. A transfer accepted on the input passes through the angle-to-phase
// multiply register, the table read register and the register stages of the
// interpolation lanes before it appears on out_valid. A new angle is accepted
// every cycle while the output is not stalled; the table banks are read at two
// addresses each per cycle, which sets that rate.
//
// Stall. While a result is shown and out_stall is high, the whole pipeline
// holds and in_stall is raised; nothing is lost or repeated. When the output
// is empty or is taken in that cycle, the input keeps flowing.
//
// Reset. rst_n is synchronous and active low; it clears every stage's valid
// flag. The table is a constant, so no clearing pass follows reset.
module sin_cos_table_hermite #(
  parameter int TABLE_SIZE    = sct_pkg::TABLE_SIZE_DEF,
  parameter int OUT_FRAC_BITS = sct_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                in_angle_rad,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sct_pkg::OUT_W-1:0]  out_sine_out,
  output logic signed [sct_pkg::OUT_W-1:0]  out_cosine_out
);

  localparam int IB   = $clog2(TABLE_SIZE);
  localparam int NSTG = 2 + sct_pkg::LANE_LAT;

  // Phase correction for a negative angle: the sign extension adds -2^32 times
  // the scale factor, which lands in the phase as the low scale bits shifted up.
  localparam logic [31:0] SIGN_FIX = {sct_pkg::INV_TWO_PI_Q32[15:0], 16'd0};

  logic                en;
  logic [NSTG-1:0]     vld_r;
  logic [63:0]         phase_prod;
  logic [31:0]         phase_r;
  logic [IB-1:0]       sin_idx;
  logic [IB-1:0]       cos_idx;
  logic [31:0]         frac_full;
  sct_pkg::frac_t      frac_r;
  sct_pkg::rom_pair_t  sin_pair;
  sct_pkg::rom_pair_t  cos_pair;
  sct_pkg::rom_pair_t  neg_sin_pair;

  // Pipeline enable: hold everything while the shown result is stalled.
  assign en        = !(vld_r[NSTG-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[NSTG-1];

  // Valid flags for every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Angle times 1/(2*pi) as an unsigned 32 by 32 multiply. For a negative
  // angle the phase bits are then corrected for the missing sign extension.
  assign phase_prod = $unsigned(in_angle_rad) * sct_pkg::INV_TWO_PI_Q32;

  always_ff @(posedge clk) begin
    if (en) begin
      phase_r <= phase_prod[47:16] - (in_angle_rad[31] ? SIGN_FIX : 32'd0);
    end
  end

  // Table indices and interpolation fraction from the phase.
  assign sin_idx   = phase_r[31 -: IB];
  assign cos_idx   = sin_idx + IB'(TABLE_SIZE / 4);
  assign frac_full = {phase_r[31-IB:0], {IB{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      frac_r <= frac_full[31:2];
    end
  end

  sct_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_rom (
    .clk        (clk),
    .en         (en),
    .sin_idx_i  (sin_idx),
    .cos_idx_i  (cos_idx),
    .sin_pair_o (sin_pair),
    .cos_pair_o (cos_pair)
  );

  // The cosine slopes are the negated sine values.
  assign neg_sin_pair.lo = -sin_pair.lo;
  assign neg_sin_pair.hi = -sin_pair.hi;

  sct_lane #(
    .TABLE_SIZE    (TABLE_SIZE),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_sin_lane (
    .clk     (clk),
    .en      (en),
    .own_i   (sin_pair),
    .slope_i (cos_pair),
    .t_i     (frac_r),
    .value_o (out_sine_out)
  );

  sct_lane #(
    .TABLE_SIZE    (TABLE_SIZE),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_cos_lane (
    .clk     (clk),
    .en      (en),
    .own_i   (cos_pair),
    .slope_i (neg_sin_pair),
    .t_i     (frac_r),
    .value_o (out_cosine_out)
  );

endmodule

/* src/sct_checker.sv */
// Port-level checker for the sine/cosine unit and its bind to the top level.
module sct_checker #(
  parameter int OUT_FRAC_BITS = sct_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [sct_pkg::OUT_W-1:0]  out_sine_out,
  input logic signed [sct_pkg::OUT_W-1:0]  out_cosine_out
);

  localparam int LIM_HI = (OUT_FRAC_BITS >= 15) ? 32767 : (1 << OUT_FRAC_BITS);
  localparam int LIM_LO = (OUT_FRAC_BITS >= 15) ? -32768 : -(1 << OUT_FRAC_BITS);

  // A stalled result stays on the output.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sine_out) && $stable(out_cosine_out))
    else $error("stalled result changed");

  // The input is held back only by a stalled result on the output.
  a_in_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Both results stay within plus or minus one.
  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sine_out <= LIM_HI && out_sine_out >= LIM_LO &&
                  out_cosine_out <= LIM_HI && out_cosine_out >= LIM_LO)
    else $error("result outside plus or minus one");

endmodule

bind sin_cos_table_hermite sct_checker #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_sct_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sine_out   (out_sine_out),
  .out_cosine_out (out_cosine_out)
);
